@@ hw/rtl/cfi_pkg.sv @@
package cfi_pkg;

  // sequencer states of the top level
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_ERASE
  } state_t;

  // read modes of one bank
  typedef enum logic [1:0] {
    MODE_ARRAY,
    MODE_STATUS,
    MODE_ID,
    MODE_QUERY
  } mode_t;

  // program phases of one bank
  typedef enum logic [2:0] {
    PH_NONE,
    PH_WORD,
    PH_ERASE,
    PH_BUFCNT,
    PH_BUFDATA,
    PH_BUFCONF
  } phase_t;

  // request types
  localparam logic [1:0] REQ_READ   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_LOAD   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // command codes
  localparam logic [7:0] CMD_READ_ARRAY     = 8'hff;
  localparam logic [7:0] CMD_READ_ARRAY_ALT = 8'hf0;
  localparam logic [7:0] CMD_READ_STATUS    = 8'h70;
  localparam logic [7:0] CMD_CLEAR_STATUS   = 8'h50;
  localparam logic [7:0] CMD_READ_ID        = 8'h90;
  localparam logic [7:0] CMD_QUERY          = 8'h98;
  localparam logic [7:0] CMD_WORD_PROG      = 8'h10;
  localparam logic [7:0] CMD_WORD_PROG_ALT  = 8'h40;
  localparam logic [7:0] CMD_ERASE          = 8'h20;
  localparam logic [7:0] CMD_BUF_PROG       = 8'he8;
  localparam logic [7:0] CMD_CONFIRM        = 8'hd0;

  localparam logic [7:0] STATUS_READY = 8'h80;
  localparam logic [7:0] ID_MANUF     = 8'h89;
  localparam logic [7:0] ID_DEVICE    = 8'h18;

  localparam int unsigned BUF_CNT_W = 17;

  // request from the sequencer to the bank command logic
  typedef struct packed {
    logic        exec;
    logic        bank;
    logic [7:0]  code;
    logic [15:0] count;
  } cmd_req_t;

  // controls back from the bank command logic
  typedef struct packed {
    logic       prog;
    logic       erase;
    mode_t      mode;
    logic [7:0] status;
  } cmd_ctl_t;

  // query table by word offset
  function automatic logic [7:0] query_byte(input logic [19:0] w);
    logic [7:0] q;
    case (w)
      20'h10:  q = 8'h51;
      20'h11:  q = 8'h52;
      20'h12:  q = 8'h59;
      20'h13:  q = 8'h01;
      20'h27:  q = 8'h1a;
      20'h28:  q = 8'h02;
      20'h2a:  q = 8'h05;
      20'h2c:  q = 8'h01;
      20'h2d:  q = 8'hff;
      20'h30:  q = 8'h04;
      default: q = 8'h00;
    endcase
    return q;
  endfunction

endpackage

@@ hw/rtl/cfi_req_if.sv @@
interface cfi_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [19:0] offset;
  logic [3:0]  access_size;
  logic [63:0] write_data;

  modport source (output valid, req_type, offset, access_size, write_data, input ready);
  modport sink (input valid, req_type, offset, access_size, write_data, output ready);
endinterface

@@ hw/rtl/cfi_rsp_if.sv @@
interface cfi_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic        addr_err;

  modport source (output valid, read_data, addr_err, input ready);
  modport sink (input valid, read_data, addr_err, output ready);
endinterface

@@ hw/rtl/nor_flash_cfi_command_controller_top.sv @@
// NOR flash array with a two-bank CFI-style command set.
// Items enter on in_req (valid/ready) and each gives one item on out_rsp:
// read data little-endian for reads, zero otherwise, with addr_err set
// when offset plus size runs past the array end, never for the unused type.
// The array is held in eight byte-lane memories with registered reads; an
// item is read in the accept cycle and modified and written back in the
// next, so no new item is accepted until the sequencer is back in idle.
// A block erase confirm then sweeps the block, up to the array end, one row
// of 8 bytes a cycle, with in_req held off.
// After reset a clearing pass zeroes the array, all ARRAY_BYTES/8 rows
// (131072 at the default size), before the first item is accepted; bank
// state returns to array mode with no operation pending.
// A result waits in the output register while out_rsp is stalled; one more
// item is accepted and its result parked in a second register, after which
// in_req.ready stays low until the parked result moves to the output.
module nor_flash_cfi_command_controller_top #(
  parameter int unsigned ARRAY_BYTES       = 1048576,
  parameter int unsigned BANK_BYTES        = 524288,
  parameter int unsigned ERASE_BLOCK_BYTES = 262144
) (
  input logic       clk,
  input logic       rst_n,
  cfi_req_if.sink   in_req,
  cfi_rsp_if.source out_rsp
);

  localparam int unsigned ROWS = ARRAY_BYTES / 8;
  localparam int unsigned RW   = $clog2(ROWS);

  cfi_pkg::state_t state_r, state_nxt;

  logic [1:0]  type_r;
  logic [19:0] off_r;
  logic [3:0]  n_r;
  logic [63:0] data_r;
  logic [RW-1:0] rd_addr_r [8];
  logic [RW-1:0] rd_addr   [8];

  logic [RW-1:0] sweep_row_r, sweep_last_r;
  logic          sweep_end;

  logic          lane_we    [8];
  logic [RW-1:0] lane_waddr [8];
  logic [7:0]    lane_wdata [8];
  logic [7:0]    lane_q     [8];

  logic          accept;
  logic [16:0]   row0;
  logic [17:0]   row1;
  logic [2:0]    s;
  logic [31:0]   end32, base32, lim32;
  logic          fault, ok, bank, erase_go;
  logic [19:0]   boff;
  logic [63:0]   arr_val, mode_val, res_data;
  logic [7:0]    rd_byte [8];

  cfi_pkg::cmd_req_t creq;
  cfi_pkg::cmd_ctl_t ctl;

  logic        out_valid_r, pend_valid_r, out_free;
  logic [63:0] out_data_r, pend_data_r;
  logic        out_fault_r, pend_fault_r;

  assign accept   = in_req.valid && in_req.ready;
  assign out_free = !out_valid_r || out_rsp.ready;

  // lane read addresses: lanes below the start lane read the next row
  assign row0 = in_req.offset[19:3];
  assign row1 = {1'b0, row0} + 18'd1;
  always_comb begin
    for (int l = 0; l < 8; l++) begin
      rd_addr[l] = (3'(l) < in_req.offset[2:0]) ? RW'(row1) : RW'(row0);
    end
  end

  // byte-lane memories
  for (genvar g = 0; g < 8; g++) begin : g_lane
    cfi_lane_ram #(.DEPTH(ROWS), .AW(RW)) u_ram (
      .clk   (clk),
      .we    (lane_we[g]),
      .waddr (lane_waddr[g]),
      .wdata (lane_wdata[g]),
      .re    (accept),
      .raddr (rd_addr[g]),
      .rdata (lane_q[g])
    );
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      type_r    <= in_req.req_type;
      off_r     <= in_req.offset;
      n_r       <= (in_req.access_size > 4'd8) ? 4'd8 : in_req.access_size;
      data_r    <= in_req.write_data;
      rd_addr_r <= rd_addr;
    end
  end

  // access decode, the unused request type never faults
  assign s      = off_r[2:0];
  assign end32  = {12'b0, off_r} + {28'b0, n_r};
  assign fault  = end32 > ARRAY_BYTES && type_r != cfi_pkg::REQ_UNUSED;
  assign ok     = type_r != cfi_pkg::REQ_UNUSED && !fault;
  assign bank   = {12'b0, off_r} >= BANK_BYTES;
  assign boff   = off_r & 20'(BANK_BYTES - 1);

  // bank command logic
  always_comb begin
    creq.exec  = state_r == cfi_pkg::ST_EXEC && type_r == cfi_pkg::REQ_WRITE && ok;
    creq.bank  = bank;
    creq.code  = data_r[7:0];
    creq.count = data_r[15:0];
  end

  cfi_cmd u_cmd (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .ctl   (ctl)
  );

  // read result assembly
  always_comb begin
    logic [20:0] p;
    logic [7:0]  x;
    arr_val  = '0;
    mode_val = '0;
    for (int i = 0; i < 8; i++) begin
      rd_byte[i] = lane_q[3'(s + 3'(i))];
      p = {1'b0, boff} + 21'(i);
      case (ctl.mode)
        cfi_pkg::MODE_STATUS: x = (i % 2 == 1) ? 8'h00 : ctl.status;
        cfi_pkg::MODE_ID: begin
          if (p[0]) x = 8'h00;
          else if (p[20:1] == 20'd0) x = cfi_pkg::ID_MANUF;
          else if (p[20:1] == 20'd1) x = cfi_pkg::ID_DEVICE;
          else x = 8'h00;
        end
        default: x = p[0] ? 8'h00 : cfi_pkg::query_byte(p[20:1]);
      endcase
      if (4'(i) < n_r) begin
        arr_val[8*i +: 8]  = rd_byte[i];
        mode_val[8*i +: 8] = x;
      end
    end
    if (type_r == cfi_pkg::REQ_READ && ok) begin
      res_data = (ctl.mode == cfi_pkg::MODE_ARRAY) ? arr_val : mode_val;
    end else begin
      res_data = '0;
    end
  end

  // erase block bounds
  always_comb begin
    base32 = {12'b0, off_r} & ~(ERASE_BLOCK_BYTES - 1);
    lim32  = base32 + ERASE_BLOCK_BYTES;
    if (lim32 > ARRAY_BYTES) lim32 = ARRAY_BYTES;
  end
  assign erase_go  = ctl.erase && base32 < ARRAY_BYTES;
  assign sweep_end = (state_r == cfi_pkg::ST_CLEAR) ? (sweep_row_r == RW'(ROWS - 1))
                                                    : (sweep_row_r == sweep_last_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfi_pkg::ST_CLEAR: if (sweep_end) state_nxt = cfi_pkg::ST_IDLE;
      cfi_pkg::ST_IDLE:  if (accept) state_nxt = cfi_pkg::ST_EXEC;
      cfi_pkg::ST_EXEC:  state_nxt = erase_go ? cfi_pkg::ST_ERASE : cfi_pkg::ST_IDLE;
      cfi_pkg::ST_ERASE: if (sweep_end) state_nxt = cfi_pkg::ST_IDLE;
      default:           state_nxt = cfi_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: ready and memory writes
  always_comb begin
    logic [2:0] bi;
    logic [7:0] wd;
    in_req.ready = state_r == cfi_pkg::ST_IDLE && !pend_valid_r;
    for (int l = 0; l < 8; l++) begin
      bi = 3'(3'(l) - s);
      wd = data_r[8*bi +: 8];
      lane_we[l]    = 1'b0;
      lane_waddr[l] = sweep_row_r;
      lane_wdata[l] = 8'h00;
      case (state_r)
        cfi_pkg::ST_CLEAR: lane_we[l] = 1'b1;
        cfi_pkg::ST_ERASE: begin
          lane_we[l]    = 1'b1;
          lane_wdata[l] = 8'hff;
        end
        cfi_pkg::ST_EXEC: begin
          lane_waddr[l] = rd_addr_r[l];
          lane_wdata[l] = (type_r == cfi_pkg::REQ_LOAD) ? wd : (lane_q[l] & wd);
          lane_we[l]    = ({1'b0, bi} < n_r) &&
                          ((type_r == cfi_pkg::REQ_LOAD && ok) || ctl.prog);
        end
        default: ;
      endcase
    end
  end

  // state and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= cfi_pkg::ST_CLEAR;
      sweep_row_r  <= '0;
      sweep_last_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cfi_pkg::ST_CLEAR || state_r == cfi_pkg::ST_ERASE) begin
        sweep_row_r <= sweep_row_r + RW'(1);
      end else if (state_r == cfi_pkg::ST_EXEC && erase_go) begin
        sweep_row_r  <= RW'(base32 >> 3);
        sweep_last_r <= RW'((lim32 >> 3) - 32'd1);
      end
    end
  end

  // output register and parking register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else if (state_r == cfi_pkg::ST_EXEC) begin
      if (out_free) out_valid_r <= 1'b1;
      else pend_valid_r <= 1'b1;
    end else if (out_free) begin
      out_valid_r  <= pend_valid_r;
      pend_valid_r <= 1'b0;
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    if (state_r == cfi_pkg::ST_EXEC) begin
      if (out_free) begin
        out_data_r  <= res_data;
        out_fault_r <= fault;
      end else begin
        pend_data_r  <= res_data;
        pend_fault_r <= fault;
      end
    end else if (out_free && pend_valid_r) begin
      out_data_r  <= pend_data_r;
      out_fault_r <= pend_fault_r;
    end
  end

  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.read_data = out_data_r;
  assign out_rsp.addr_err  = out_fault_r;

  // checks
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r) else $error("parked result without output");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fault_r |-> out_data_r == 64'd0) else $error("fault with data");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == cfi_pkg::ST_EXEC) else $error("accept without execute");

  a_erase_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == cfi_pkg::ST_EXEC && erase_go |=> state_r == cfi_pkg::ST_ERASE)
    else $error("erase confirm without sweep");

endmodule

@@ hw/rtl/cfi_lane_ram.sv @@
module cfi_lane_ram #(
  parameter int unsigned DEPTH = 131072,
  parameter int unsigned AW    = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/cfi_cmd.sv @@
module cfi_cmd (
  input  logic              clk,
  input  logic              rst_n,
  input  cfi_pkg::cmd_req_t req,
  output cfi_pkg::cmd_ctl_t ctl
);

  cfi_pkg::mode_t                 mode_r  [2];
  cfi_pkg::mode_t                 mode_nxt[2];
  cfi_pkg::phase_t                ph_r    [2];
  cfi_pkg::phase_t                ph_nxt  [2];
  logic [7:0]                     stat_r  [2];
  logic [7:0]                     stat_nxt[2];
  logic [cfi_pkg::BUF_CNT_W-1:0]  cnt_r   [2];
  logic [cfi_pkg::BUF_CNT_W-1:0]  cnt_nxt [2];
  logic [cfi_pkg::BUF_CNT_W-1:0]  seen_r  [2];
  logic [cfi_pkg::BUF_CNT_W-1:0]  seen_nxt[2];
  logic [cfi_pkg::BUF_CNT_W-1:0]  seen_inc;
  cfi_pkg::phase_t                ph;

  assign ph       = ph_r[req.bank];
  assign seen_inc = seen_r[req.bank] + 17'd1;

  // controls for the selected bank
  always_comb begin
    ctl.mode   = mode_r[req.bank];
    ctl.status = stat_r[req.bank];
    ctl.prog   = req.exec && (ph == cfi_pkg::PH_WORD || ph == cfi_pkg::PH_BUFDATA);
    ctl.erase  = req.exec && ph == cfi_pkg::PH_ERASE && req.code == cfi_pkg::CMD_CONFIRM;
  end

  // command state machine next state
  always_comb begin
    mode_nxt = mode_r;
    ph_nxt   = ph_r;
    stat_nxt = stat_r;
    cnt_nxt  = cnt_r;
    seen_nxt = seen_r;
    if (req.exec) begin
      case (ph)
        cfi_pkg::PH_WORD: begin
          ph_nxt[req.bank]   = cfi_pkg::PH_NONE;
          mode_nxt[req.bank] = cfi_pkg::MODE_STATUS;
        end
        cfi_pkg::PH_BUFCNT: begin
          cnt_nxt[req.bank]  = {1'b0, req.count} + 17'd1;
          seen_nxt[req.bank] = '0;
          ph_nxt[req.bank]   = cfi_pkg::PH_BUFDATA;
        end
        cfi_pkg::PH_BUFDATA: begin
          seen_nxt[req.bank] = seen_inc;
          if (seen_inc >= cnt_r[req.bank]) begin
            ph_nxt[req.bank] = cfi_pkg::PH_BUFCONF;
          end
        end
        cfi_pkg::PH_BUFCONF: begin
          if (req.code == cfi_pkg::CMD_CONFIRM) begin
            ph_nxt[req.bank]   = cfi_pkg::PH_NONE;
            mode_nxt[req.bank] = cfi_pkg::MODE_STATUS;
          end
        end
        cfi_pkg::PH_ERASE: begin
          if (req.code == cfi_pkg::CMD_CONFIRM) begin
            stat_nxt[req.bank] = cfi_pkg::STATUS_READY;
            ph_nxt[req.bank]   = cfi_pkg::PH_NONE;
            mode_nxt[req.bank] = cfi_pkg::MODE_STATUS;
          end
        end
        default: begin
          case (req.code)
            cfi_pkg::CMD_READ_ARRAY, cfi_pkg::CMD_READ_ARRAY_ALT:
              mode_nxt[req.bank] = cfi_pkg::MODE_ARRAY;
            cfi_pkg::CMD_READ_STATUS: mode_nxt[req.bank] = cfi_pkg::MODE_STATUS;
            cfi_pkg::CMD_CLEAR_STATUS: stat_nxt[req.bank] = cfi_pkg::STATUS_READY;
            cfi_pkg::CMD_READ_ID: mode_nxt[req.bank] = cfi_pkg::MODE_ID;
            cfi_pkg::CMD_QUERY: mode_nxt[req.bank] = cfi_pkg::MODE_QUERY;
            cfi_pkg::CMD_WORD_PROG, cfi_pkg::CMD_WORD_PROG_ALT: begin
              ph_nxt[req.bank]   = cfi_pkg::PH_WORD;
              mode_nxt[req.bank] = cfi_pkg::MODE_STATUS;
            end
            cfi_pkg::CMD_ERASE: begin
              ph_nxt[req.bank]   = cfi_pkg::PH_ERASE;
              mode_nxt[req.bank] = cfi_pkg::MODE_STATUS;
            end
            cfi_pkg::CMD_BUF_PROG: begin
              ph_nxt[req.bank]   = cfi_pkg::PH_BUFCNT;
              mode_nxt[req.bank] = cfi_pkg::MODE_STATUS;
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  // bank state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < 2; b++) begin
        mode_r[b] <= cfi_pkg::MODE_ARRAY;
        ph_r[b]   <= cfi_pkg::PH_NONE;
        stat_r[b] <= cfi_pkg::STATUS_READY;
        cnt_r[b]  <= '0;
        seen_r[b] <= '0;
      end
    end else begin
      mode_r <= mode_nxt;
      ph_r   <= ph_nxt;
      stat_r <= stat_nxt;
      cnt_r  <= cnt_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FLASH_BYTES = 1048576;
  localparam int unsigned BANK_SPAN   = 524288;
  localparam int unsigned BLOCK_SPAN  = 262144;
  localparam logic [19:0] BANK1_BASE  = 20'h80000;
  localparam int unsigned RAND_ITEMS  = 1850;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 40;

  // one input item, with an optional typed-in result
  typedef struct {
    logic [1:0]  kind;
    logic [19:0] off;
    logic [3:0]  size;
    logic [63:0] data;
    bit          fixed;
    logic [63:0] fix_data;
    logic        fix_fault;
  } flash_req_t;

  typedef struct {
    logic [63:0] data;
    logic        fault;
  } flash_rsp_t;

  logic clk;
  logic rst_n;

  cfi_req_if req_bus ();
  cfi_rsp_if rsp_bus ();

  nor_flash_cfi_command_controller_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_bus),
    .out_rsp (rsp_bus)
  );

  // shadow of the flash array and the bank command state
  logic [7:0]       flash_img [0:FLASH_BYTES-1];
  cfi_pkg::mode_t   bank_mode  [2];
  cfi_pkg::phase_t  bank_phase [2];
  logic [7:0]       bank_stat  [2];
  logic [16:0]      buf_total  [2];
  logic [16:0]      buf_done   [2];

  flash_rsp_t  pending_rsp [$];
  flash_req_t  directed [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_asks;
  int unsigned hold_taken;
  int unsigned hold_left;
  int unsigned erase_budget;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // own copy of the cfi query table
  function automatic logic [7:0] cfi_table(input logic [18:0] w);
    logic [7:0] q;
    case (w)
      19'h10:  q = 8'h51;
      19'h11:  q = 8'h52;
      19'h12:  q = 8'h59;
      19'h13:  q = 8'h01;
      19'h27:  q = 8'h1a;
      19'h28:  q = 8'h02;
      19'h2a:  q = 8'h05;
      19'h2c:  q = 8'h01;
      19'h2d:  q = 8'hff;
      19'h30:  q = 8'h04;
      default: q = 8'h00;
    endcase
    return q;
  endfunction

  // apply one item to the shadow state and work out its result
  function automatic flash_rsp_t flash_access(input flash_req_t r);
    flash_rsp_t  res;
    int unsigned n;
    int unsigned b;
    int unsigned base;
    logic [19:0] boff;
    logic [7:0]  x;
    logic [7:0]  code;
    res.data  = '0;
    res.fault = 1'b0;
    n = (r.size > 4'd8) ? 8 : r.size;
    code = r.data[7:0];
    if (r.kind == cfi_pkg::REQ_UNUSED) return res;
    if (r.off + n > FLASH_BYTES) begin
      res.fault = 1'b1;
      return res;
    end
    b = (r.off >= BANK1_BASE) ? 1 : 0;
    if (r.kind == cfi_pkg::REQ_READ) begin
      for (int i = 0; i < n; i++) begin
        // position within the bank, may run up to seven bytes past the bank end
        boff = {1'b0, r.off[18:0]} + 20'(i);
        if (bank_mode[b] == cfi_pkg::MODE_ARRAY) x = flash_img[r.off + i];
        else if (bank_mode[b] == cfi_pkg::MODE_STATUS) x = i[0] ? 8'h00 : bank_stat[b];
        else if (bank_mode[b] == cfi_pkg::MODE_ID)
          x = boff[0] ? 8'h00 : (boff[19:1] == 0 ? cfi_pkg::ID_MANUF :
                                 (boff[19:1] == 1 ? cfi_pkg::ID_DEVICE : 8'h00));
        else x = boff[0] ? 8'h00 : cfi_table(boff[19:1]);
        res.data[i*8 +: 8] = x;
      end
    end else if (r.kind == cfi_pkg::REQ_LOAD) begin
      for (int i = 0; i < n; i++) flash_img[r.off + i] = r.data[i*8 +: 8];
    end else begin
      case (bank_phase[b])
        cfi_pkg::PH_WORD: begin
          for (int i = 0; i < n; i++) flash_img[r.off + i] &= r.data[i*8 +: 8];
          bank_phase[b] = cfi_pkg::PH_NONE;
          bank_mode[b]  = cfi_pkg::MODE_STATUS;
        end
        cfi_pkg::PH_BUFCNT: begin
          buf_total[b]  = {1'b0, r.data[15:0]} + 17'd1;
          buf_done[b]   = '0;
          bank_phase[b] = cfi_pkg::PH_BUFDATA;
        end
        cfi_pkg::PH_BUFDATA: begin
          for (int i = 0; i < n; i++) flash_img[r.off + i] &= r.data[i*8 +: 8];
          buf_done[b] = buf_done[b] + 17'd1;
          if (buf_done[b] >= buf_total[b]) bank_phase[b] = cfi_pkg::PH_BUFCONF;
        end
        cfi_pkg::PH_BUFCONF: begin
          if (code == cfi_pkg::CMD_CONFIRM) begin
            bank_phase[b] = cfi_pkg::PH_NONE;
            bank_mode[b]  = cfi_pkg::MODE_STATUS;
          end
        end
        cfi_pkg::PH_ERASE: begin
          if (code == cfi_pkg::CMD_CONFIRM) begin
            base = r.off & ~(BLOCK_SPAN - 1);
            for (int i = 0; i < BLOCK_SPAN; i++)
              if (base + i < FLASH_BYTES) flash_img[base + i] = 8'hff;
            bank_stat[b]  = cfi_pkg::STATUS_READY;
            bank_phase[b] = cfi_pkg::PH_NONE;
            bank_mode[b]  = cfi_pkg::MODE_STATUS;
          end
        end
        default: begin
          case (code)
            cfi_pkg::CMD_READ_ARRAY, cfi_pkg::CMD_READ_ARRAY_ALT:
              bank_mode[b] = cfi_pkg::MODE_ARRAY;
            cfi_pkg::CMD_READ_STATUS:  bank_mode[b] = cfi_pkg::MODE_STATUS;
            cfi_pkg::CMD_CLEAR_STATUS: bank_stat[b] = cfi_pkg::STATUS_READY;
            cfi_pkg::CMD_READ_ID:      bank_mode[b] = cfi_pkg::MODE_ID;
            cfi_pkg::CMD_QUERY:        bank_mode[b] = cfi_pkg::MODE_QUERY;
            cfi_pkg::CMD_WORD_PROG, cfi_pkg::CMD_WORD_PROG_ALT: begin
              bank_phase[b] = cfi_pkg::PH_WORD;
              bank_mode[b]  = cfi_pkg::MODE_STATUS;
            end
            cfi_pkg::CMD_ERASE: begin
              bank_phase[b] = cfi_pkg::PH_ERASE;
              bank_mode[b]  = cfi_pkg::MODE_STATUS;
            end
            cfi_pkg::CMD_BUF_PROG: begin
              bank_phase[b] = cfi_pkg::PH_BUFCNT;
              bank_mode[b]  = cfi_pkg::MODE_STATUS;
            end
            default: ;
          endcase
        end
      endcase
    end
    return res;
  endfunction

  // offer one item, wait for acceptance, then record what must come back
  task automatic send_req(input flash_req_t r);
    flash_rsp_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.req_type    <= r.kind;
    req_bus.offset      <= r.off;
    req_bus.access_size <= r.size;
    req_bus.write_data  <= r.data;
    do @(posedge clk); while (!req_bus.ready);
    res = flash_access(r);
    if (r.fixed) begin
      res.data  = r.fix_data;
      res.fault = r.fix_fault;
    end
    pending_rsp.push_back(res);
  endtask

  task automatic issue(input logic [1:0] k, input logic [19:0] o, input logic [3:0] s,
                       input logic [63:0] d);
    flash_req_t r;
    r = '{k, o, s, d, 1'b0, 64'd0, 1'b0};
    send_req(r);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] with_code(input logic [7:0] c);
    logic [63:0] d;
    d = rand64();
    d[7:0] = c;
    return d;
  endfunction

  function automatic logic [3:0] rand_size();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 5) return 4'd0;
    if (p < 12) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  // offsets bunched in a few windows so that written bytes are read back
  function automatic logic [19:0] rand_off(input int unsigned b);
    int unsigned p;
    logic [19:0] base;
    p = $urandom_range(99);
    base = b ? BANK1_BASE : 20'h0;
    if (p < 60) return base + 20'($urandom_range(0, 255));
    if (p < 72) return base + 20'($urandom_range(BLOCK_SPAN - 64, BLOCK_SPAN + 63));
    if (p < 85) return b ? 20'($urandom_range(FLASH_BYTES - 24, FLASH_BYTES - 1))
                         : 20'($urandom_range(BANK_SPAN - 24, BANK_SPAN - 1));
    return base + 20'($urandom_range(0, BANK_SPAN - 1));
  endfunction

  function automatic logic [7:0] rand_mode_cmd();
    case ($urandom_range(0, 6))
      0: return cfi_pkg::CMD_READ_ARRAY;
      1: return cfi_pkg::CMD_READ_ARRAY_ALT;
      2: return cfi_pkg::CMD_READ_STATUS;
      3: return cfi_pkg::CMD_CLEAR_STATUS;
      4: return cfi_pkg::CMD_READ_ID;
      5: return cfi_pkg::CMD_QUERY;
      default: return 8'($urandom);
    endcase
  endfunction

  // one random operation, often a whole command sequence
  task automatic rand_op();
    int unsigned p;
    int unsigned b;
    int unsigned cnt;
    p = $urandom_range(99);
    b = $urandom_range(1);
    if (p < 30) begin
      issue(cfi_pkg::REQ_READ, rand_off(b), rand_size(), rand64());
    end else if (p < 45) begin
      issue(cfi_pkg::REQ_LOAD, rand_off(b), rand_size(), rand64());
    end else if (p < 58) begin
      issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(),
            with_code($urandom_range(1) ? cfi_pkg::CMD_WORD_PROG
                                        : cfi_pkg::CMD_WORD_PROG_ALT));
      issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), rand64());
      issue(cfi_pkg::REQ_READ, rand_off(b), rand_size(), rand64());
    end else if (p < 70) begin
      cnt = $urandom_range(0, 3);
      issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), with_code(cfi_pkg::CMD_BUF_PROG));
      issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), {rand64() & ~64'hffff} | 64'(cnt));
      for (int i = 0; i <= cnt; i++)
        issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), rand64());
      if ($urandom_range(3) == 0)
        issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), rand64());
      issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), with_code(cfi_pkg::CMD_CONFIRM));
      issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), with_code(cfi_pkg::CMD_READ_ARRAY));
    end else if (p < 90) begin
      issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), with_code(rand_mode_cmd()));
      issue(cfi_pkg::REQ_READ, rand_off(b), rand_size(), rand64());
    end else if (p < 92 && erase_budget > 0) begin
      erase_budget--;
      issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), with_code(cfi_pkg::CMD_ERASE));
      if ($urandom_range(1)) issue(cfi_pkg::REQ_WRITE, rand_off(b), rand_size(), rand64());
      issue(cfi_pkg::REQ_WRITE, rand_off(b), 4'd1, with_code(cfi_pkg::CMD_CONFIRM));
    end else begin
      // noise: unused type, bad sizes, accesses past the end
      case ($urandom_range(0, 2))
        0: issue(cfi_pkg::REQ_UNUSED, 20'($urandom), 4'($urandom), rand64());
        1: issue(2'($urandom_range(0, 2)), 20'($urandom_range(FLASH_BYTES - 8,
                 FLASH_BYTES - 1)), 4'($urandom_range(0, 15)), rand64());
        default: issue(2'($urandom_range(0, 2)), 20'($urandom), 4'($urandom), rand64());
      endcase
    end
  endtask

  task automatic add_row(input logic [1:0] k, input logic [19:0] o, input logic [3:0] s,
                         input logic [63:0] d, input bit fx, input logic [63:0] fd,
                         input logic ff);
    flash_req_t r;
    r = '{k, o, s, d, fx, fd, ff};
    directed.push_back(r);
  endtask

  task automatic drain_wait();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (hold_left != 0) begin
      rsp_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != hold_taken) begin
      rsp_bus.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= hold_asks;
    end else begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    flash_rsp_t want;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("result with no item outstanding: read_data %h addr_err %b",
               rsp_bus.read_data, rsp_bus.addr_err);
        err_cnt++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.read_data !== want.data) begin
          $error("read_data: expected %h, got %h", want.data, rsp_bus.read_data);
          err_cnt++;
        end
        if (rsp_bus.addr_err !== want.fault) begin
          $error("addr_err: expected %b, got %b", want.fault, rsp_bus.addr_err);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned waited;
    err_cnt = 0;
    cycle_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asks = 0;
    hold_taken = 0;
    hold_left = 0;
    erase_budget = 5;
    rst_n = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = cfi_pkg::REQ_READ;
    req_bus.offset = '0;
    req_bus.access_size = '0;
    req_bus.write_data = '0;
    rsp_bus.ready = 1'b0;
    for (int i = 0; i < FLASH_BYTES; i++) flash_img[i] = 8'h00;
    for (int b = 0; b < 2; b++) begin
      bank_mode[b] = cfi_pkg::MODE_ARRAY;
      bank_phase[b] = cfi_pkg::PH_NONE;
      bank_stat[b] = cfi_pkg::STATUS_READY;
      buf_total[b] = '0;
      buf_done[b] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    add_row(cfi_pkg::REQ_READ, 20'h0, 4'd8, '0, 1, 64'd0, 1'b0);
    add_row(cfi_pkg::REQ_LOAD, 20'h0, 4'd8, 64'hffff_ffff_ffff_ffff, 0, '0, 0);
    add_row(cfi_pkg::REQ_LOAD, 20'hffff8, 4'd8, 64'h0123_4567_89ab_cdef, 0, '0, 0);
    add_row(cfi_pkg::REQ_READ, 20'hffff8, 4'd8, '0, 0, '0, 0);
    add_row(cfi_pkg::REQ_READ, 20'hffffc, 4'd8, '0, 1, 64'd0, 1'b1);
    add_row(cfi_pkg::REQ_LOAD, 20'hfffff, 4'd2, '1, 1, 64'd0, 1'b1);
    add_row(cfi_pkg::REQ_READ, 20'h0, 4'd0, '0, 1, 64'd0, 1'b0);
    add_row(cfi_pkg::REQ_READ, 20'hffff8, 4'd15, '0, 0, '0, 0);
    add_row(cfi_pkg::REQ_UNUSED, 20'hfffff, 4'd15, '1, 1, 64'd0, 1'b0);
    add_row(cfi_pkg::REQ_WRITE, 20'h0, 4'd1, 64'(cfi_pkg::CMD_READ_ID), 0, '0, 0);
    add_row(cfi_pkg::REQ_READ, 20'h0, 4'd4, '0, 1, 64'h0000_0000_0018_0089, 1'b0);
    add_row(cfi_pkg::REQ_WRITE, BANK1_BASE, 4'd1, 64'(cfi_pkg::CMD_QUERY), 0, '0, 0);
    add_row(cfi_pkg::REQ_READ, BANK1_BASE + 20'h20, 4'd8, '0, 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, 20'h10, 4'd2, 64'(cfi_pkg::CMD_WORD_PROG_ALT), 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, 20'h0, 4'd8, 64'h5a5a_0f0f_3c3c_0000, 0, '0, 0);
    add_row(cfi_pkg::REQ_READ, 20'h3, 4'd8, '0, 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, 20'h0, 4'd1, 64'(cfi_pkg::CMD_CLEAR_STATUS), 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, 20'h0, 4'd1, 64'(cfi_pkg::CMD_READ_ARRAY_ALT), 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, BANK1_BASE, 4'd1, 64'(cfi_pkg::CMD_BUF_PROG), 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, BANK1_BASE, 4'd2, 64'h1, 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, 20'hffff8, 4'd8, 64'h00ff_00ff_00ff_00ff, 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, BANK1_BASE, 4'd0, 64'h0, 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, BANK1_BASE, 4'd1, 64'(cfi_pkg::CMD_READ_STATUS), 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, BANK1_BASE, 4'd1, 64'(cfi_pkg::CMD_CONFIRM), 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, 20'hc0000, 4'd1, 64'(cfi_pkg::CMD_ERASE), 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, 20'hc0000, 4'd1, 64'(cfi_pkg::CMD_CONFIRM), 0, '0, 0);
    add_row(cfi_pkg::REQ_WRITE, 20'hc0000, 4'd1, 64'(cfi_pkg::CMD_READ_ARRAY), 0, '0, 0);
    add_row(cfi_pkg::REQ_READ, 20'hffff8, 4'd8, '0, 0, '0, 0);
    foreach (directed[i]) send_req(directed[i]);

    // random part in four idling phases; long hold-off and a full pause on the way
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      if (ph == 1) hold_asks++;
      if (ph == 2) begin
        req_bus.valid <= 1'b0;
        drain_wait();
      end
      for (int k = 0; k < RAND_ITEMS / 4 / 2; k++) begin
        rand_op();
        if (k == 60) send_idle_pct = 0;
        if (k == 120 && ph != 0) send_idle_pct = (ph == 1) ? 63 : ((ph == 2) ? 0 : 29);
      end
    end

    @(posedge clk);
    req_bus.valid <= 1'b0;
    drain_wait();
    waited = 0;
    while (waited < DRAIN_WAIT) begin
      @(posedge clk);
      waited++;
    end
    if (err_cnt == 0 && pending_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ nor_flash_cfi_command_controller_top.f @@
hw/rtl/cfi_pkg.sv
hw/rtl/cfi_req_if.sv
hw/rtl/cfi_rsp_if.sv
hw/rtl/cfi_lane_ram.sv
hw/rtl/cfi_cmd.sv
hw/rtl/nor_flash_cfi_command_controller_top.sv
tb/sv/tb_top.sv
